[rtl/ksl_pkg.sv]
// ----------------------------------------------------------------------------
// Keyframe segment locator package
// Shared widths, defaults, item codes and the divider result bundle.
// ----------------------------------------------------------------------------
package ksl_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W    = 9;   // frame count register and internal frame numbers
  localparam int FRAME_W  = 8;   // frame index in load beats and results
  localparam int TIME_W   = 32;  // time field on the input port
  localparam int FRAC_W   = 17;  // Q0.16 fraction with room for 1.0
  localparam int QUOT_W   = 16;  // quotient bits produced by the divider

  // Parameter defaults for the top level.
  localparam int MAX_FRAMES_DEF = 256;
  localparam int TIME_BITS_DEF  = 32;

  // Fraction value for exactly 1.0.
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result bundle handed from the divider to the sequencer.
  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] fraction;
    logic              clamped;
  } div_res_t;

endpackage

[rtl/ksl_frac_div.sv]
// ----------------------------------------------------------------------------
// Keyframe segment locator blend divider
// Computes the clamped Q0.16 fraction (t-t0)/(t1-t0) with a restoring
// divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ksl_frac_div #(
  parameter int TIME_BITS = ksl_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] t0,
  input  logic [TIME_BITS-1:0] t1,
  input  logic [TIME_BITS-1:0] t,
  output ksl_pkg::div_res_t    res
);

  // The operands are held steady by the caller until done.
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_SPAN = 2'd1;
  localparam logic [1:0] D_DIFF = 2'd2;
  localparam logic [1:0] D_ITER = 2'd3;

  localparam int CNT_BITS = $clog2(ksl_pkg::QUOT_W);

  logic [1:0]                   state;
  logic                         rise;
  logic                         same;
  logic                         check;
  logic [TIME_BITS-1:0]         den;
  logic [TIME_BITS-1:0]         rem;
  logic                         below;
  logic [ksl_pkg::QUOT_W-1:0]   quot;
  logic [CNT_BITS-1:0]          cnt;

  logic [TIME_BITS:0]           rem2;
  logic                         take;
  logic [TIME_BITS:0]           rem_diff;
  logic [TIME_BITS-1:0]         rem_step;
  logic [ksl_pkg::QUOT_W-1:0]   quot_step;

  // One restoring division step.
  always_comb begin
    rem2      = {rem, 1'b0};
    take      = (rem2 >= {1'b0, den});
    rem_diff  = rem2 - {1'b0, den};
    rem_step  = take ? rem_diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
    quot_step = {quot[ksl_pkg::QUOT_W-2:0], take};
  end

  // Sequencer: span direction, differences, range check, then the bit loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      check    <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          check <= 1'b0;
          if (start) begin
            state <= D_SPAN;
          end
        end
        D_SPAN: begin
          rise  <= (t1 > t0);
          same  <= (t1 == t0);
          state <= D_DIFF;
        end
        D_DIFF: begin
          if (!check) begin
            // Distances measured in the direction of the span.
            den   <= rise ? (t1 - t0) : (t0 - t1);
            rem   <= rise ? (t - t0) : (t0 - t);
            below <= rise ? (t < t0) : (t > t0);
            check <= 1'b1;
          end else begin
            // Range check before the bit loop.
            quot <= '0;
            cnt  <= '0;
            if (same) begin
              res.fraction <= '0;
              res.clamped  <= 1'b0;
              res.done     <= 1'b1;
              state        <= D_IDLE;
            end else if (below) begin
              res.fraction <= '0;
              res.clamped  <= 1'b1;
              res.done     <= 1'b1;
              state        <= D_IDLE;
            end else if (rem > den) begin
              res.fraction <= ksl_pkg::ONE_Q16;
              res.clamped  <= 1'b1;
              res.done     <= 1'b1;
              state        <= D_IDLE;
            end else if (rem == den) begin
              res.fraction <= ksl_pkg::ONE_Q16;
              res.clamped  <= 1'b0;
              res.done     <= 1'b1;
              state        <= D_IDLE;
            end else begin
              state <= D_ITER;
            end
          end
        end
        D_ITER: begin
          rem  <= rem_step;
          quot <= quot_step;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_BITS'(ksl_pkg::QUOT_W - 1)) begin
            res.fraction <= {1'b0, quot_step};
            res.clamped  <= 1'b0;
            res.done     <= 1'b1;
            state        <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/keyframe_segment_locator_core.sv]
// ----------------------------------------------------------------------------
// Keyframe segment locator core
// Keyframe time table with cached segment lookup, backward search and a
// clamped Q0.16 blend fraction.
// ----------------------------------------------------------------------------
// A load beat writes one table entry. A query beat holds the input (in_stall
// high) until its result is in the output register. A single frame in use
// goes straight to the output; otherwise the query tries the cached segment,
// then the following segment, and after failed cache tries (or at once when
// the cached segment is stale) searches the table backward from the end.
// A zero span or a time outside the segment or on its far end skips the 16
// divider steps, and a stalled full output register holds the result back.
// The time a query takes is set by the table's single read port, which the
// search walks one entry per cycle, and by the divider, which yields one
// fraction bit per cycle. The table entries are undefined until loaded, and
// a query must only touch loaded entries. The output register lets a load
// beat be taken while a result waits.
module keyframe_segment_locator_core #(
  parameter int MAX_FRAMES = ksl_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = ksl_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ksl_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [ksl_pkg::FRAME_W-1:0]  frame_index,
  input  logic [ksl_pkg::TIME_W-1:0]   time_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ksl_pkg::FRAME_W-1:0]  first_frame,
  output logic [ksl_pkg::FRAME_W-1:0]  second_frame,
  output logic [ksl_pkg::FRAC_W-1:0]   fraction,
  output logic                         clamped
);

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int NMAX  = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
  localparam int CW    = ksl_pkg::CNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_C0     = 4'd1;
  localparam logic [3:0] S_C1     = 4'd2;
  localparam logic [3:0] S_C2     = 4'd3;
  localparam logic [3:0] S_SRCH   = 4'd4;
  localparam logic [3:0] S_F0     = 4'd5;
  localparam logic [3:0] S_F1     = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DWAIT  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Registers.
  logic [3:0]                 state, state_next;
  logic [CW-1:0]              frame_count;
  logic [CW-1:0]              cached_first;
  logic [CW-1:0]              cached_second;
  logic [CW-1:0]              n, n_next;
  logic [CW-1:0]              k, k_next;
  logic [CW-1:0]              f0, f0_next;
  logic [CW-1:0]              f1, f1_next;
  logic [TIME_BITS-1:0]       tq, tq_next;
  logic [TIME_BITS-1:0]       ta, ta_next;
  logic [TIME_BITS-1:0]       tb, tb_next;
  logic [ksl_pkg::FRAC_W-1:0] frac_r, frac_next;
  logic                       clip_r, clip_next;

  // Table memory.
  logic [TIME_BITS-1:0]       mem [MAX_FRAMES];
  logic [TIME_BITS-1:0]       rd_data;
  logic [CW-1:0]              rd_frame;
  logic                       wr_en;

  // Misc combinational.
  logic [TIME_BITS-1:0]       t_in;
  logic [CW-1:0]              n_used;
  logic [CW-1:0]              n_search;
  logic [CW-1:0]              k0;
  logic                       go_search;
  logic                       out_free;
  logic                       div_start;
  ksl_pkg::div_res_t          div_res;

  assign t_in     = TIME_BITS'(time_value);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Frames in use: zero counts as one, large values saturate.
  always_comb begin
    if (frame_count == '0) begin
      n_used = CW'(1);
    end else if (frame_count > CW'(NMAX)) begin
      n_used = CW'(NMAX);
    end else begin
      n_used = frame_count;
    end
  end

  // Frame count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CW'(1);
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // Table writes come from load beats; reads are issued by the sequencer.
  assign wr_en = (state == S_IDLE) && in_valid && (kind == ksl_pkg::KIND_LOAD) &&
                 (32'(frame_index) < 32'(MAX_FRAMES));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(frame_index)] <= t_in;
    end
    rd_data <= mem[IDX_W'(rd_frame)];
  end

  // Sequencer next-state logic; rd_frame is the entry seen in the next state.
  always_comb begin
    state_next = state;
    n_next     = n;
    k_next     = k;
    f0_next    = f0;
    f1_next    = f1;
    tq_next    = tq;
    ta_next    = ta;
    tb_next    = tb;
    frac_next  = frac_r;
    clip_next  = clip_r;
    rd_frame   = f0;
    go_search  = 1'b0;
    div_start  = 1'b0;
    n_search   = (state == S_IDLE) ? n_used : n;
    k0         = n_search - CW'(2);

    unique case (state)
      S_IDLE: begin
        if (in_valid && (kind == ksl_pkg::KIND_QUERY)) begin
          tq_next = t_in;
          n_next  = n_used;
          if (n_used == CW'(1)) begin
            f0_next    = '0;
            f1_next    = '0;
            frac_next  = '0;
            clip_next  = 1'b0;
            state_next = S_OUT;
          end else if (cached_first < n_used && cached_second < n_used) begin
            f0_next    = cached_first;
            f1_next    = cached_second;
            rd_frame   = cached_first;
            state_next = S_C0;
          end else begin
            go_search = 1'b1;
          end
        end
      end
      S_C0: begin
        ta_next    = rd_data;
        rd_frame   = f1;
        state_next = S_C1;
      end
      S_C1: begin
        // Cached segment, then the one after it.
        if (ta <= tq && tq <= rd_data) begin
          tb_next    = rd_data;
          state_next = S_DSTART;
        end else if (f1 + CW'(1) < n) begin
          ta_next    = rd_data;
          rd_frame   = f1 + CW'(1);
          state_next = S_C2;
        end else begin
          go_search = 1'b1;
        end
      end
      S_C2: begin
        if (ta <= tq && tq <= rd_data) begin
          f0_next    = f1;
          f1_next    = f1 + CW'(1);
          tb_next    = rd_data;
          state_next = S_DSTART;
        end else begin
          go_search = 1'b1;
        end
      end
      S_SRCH: begin
        // Walk down until an entry lies below the query time.
        if (rd_data < tq) begin
          f0_next    = k;
          f1_next    = k + CW'(1);
          rd_frame   = k;
          state_next = S_F0;
        end else if (k == CW'(1)) begin
          f0_next    = '0;
          f1_next    = CW'(1);
          rd_frame   = '0;
          state_next = S_F0;
        end else begin
          k_next   = k - CW'(1);
          rd_frame = k - CW'(1);
        end
      end
      S_F0: begin
        ta_next    = rd_data;
        rd_frame   = f1;
        state_next = S_F1;
      end
      S_F1: begin
        tb_next    = rd_data;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          frac_next  = div_res.fraction;
          clip_next  = div_res.clamped;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Backward search start, shared by a stale cache and every failed cache try.
    if (go_search) begin
      if (k0 == '0) begin
        f0_next    = '0;
        f1_next    = CW'(1);
        rd_frame   = '0;
        state_next = S_F0;
      end else begin
        k_next     = k0;
        rd_frame   = k0;
        state_next = S_SRCH;
      end
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    n      <= n_next;
    k      <= k_next;
    f0     <= f0_next;
    f1     <= f1_next;
    tq     <= tq_next;
    ta     <= ta_next;
    tb     <= tb_next;
    frac_r <= frac_next;
    clip_r <= clip_next;
  end

  // Segment cache, updated when a query's result is handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      cached_first  <= '0;
      cached_second <= '0;
    end else if (state == S_OUT && out_free) begin
      cached_first  <= f0;
      cached_second <= f1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == S_OUT && out_free) begin
      first_frame  <= f0[ksl_pkg::FRAME_W-1:0];
      second_frame <= f1[ksl_pkg::FRAME_W-1:0];
      fraction     <= frac_r;
      clamped      <= clip_r;
    end
  end

  // Shared divider for the blend fraction.
  ksl_frac_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .t0    (ta),
    .t1    (tb),
    .t     (tq),
    .res   (div_res)
  );

endmodule

[rtl/ksl_checker.sv]
// ----------------------------------------------------------------------------
// Keyframe segment locator checker
// Port-level assertions on the result stream, bound to the locator core.
// ----------------------------------------------------------------------------
module ksl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ksl_pkg::FRAME_W-1:0]  first_frame,
  input logic [ksl_pkg::FRAME_W-1:0]  second_frame,
  input logic [ksl_pkg::FRAC_W-1:0]   fraction,
  input logic                         clamped
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(first_frame) &&
      $stable(second_frame) && $stable(fraction) && $stable(clamped))
    else $error("result beat changed while stalled");

  // The fraction never exceeds 1.0.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !fraction[ksl_pkg::FRAC_W-1] || fraction[ksl_pkg::QUOT_W-1:0] == '0)
    else $error("fraction above one");

  // A clamped result sits on one of the two ends.
  a_clamp_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> fraction == '0 || fraction == ksl_pkg::ONE_Q16)
    else $error("clamped fraction not at an end");

  // A segment of one frame has zero span and gives a plain zero.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_frame == second_frame |-> fraction == '0 && !clamped)
    else $error("degenerate segment with nonzero fraction");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind keyframe_segment_locator_core ksl_checker u_ksl_checker (.*);
